// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define RSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define RSC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/rsc_pkg.sv -----
// Types, character constants and digit functions of the radix string converter.
package rsc_pkg;

  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [7:0] UPPER_OFFSET   = 8'd55;
  localparam logic [7:0] LOWER_OFFSET   = 8'd87;
  localparam logic [7:0] ERROR_CHAR     = 8'h00;

  localparam logic [5:0] NOT_A_DIGIT    = 6'd63;
  localparam logic [5:0] BASE_MIN       = 6'd2;
  localparam logic [5:0] BASE_MAX       = 6'd36;
  localparam logic [5:0] BASE_RESET     = 6'd10;
  localparam logic [5:0] LAST_DECIMAL   = 6'd9;

  localparam logic CFG_SOURCE_BASE = 1'b0;
  localparam logic CFG_TARGET_BASE = 1'b1;

  localparam int DIV_BITS = 8;

  typedef struct packed {
    logic take_char;
    logic decode;
    logic update;
    logic div_load;
    logic div_step;
    logic emit_err;
    logic emit_sign;
    logic emit_digit;
    logic clear_num;
  } cmd_t;

  typedef struct packed {
    logic end_mark;
    logic err_result;
    logic digit_done;
    logic quot_zero;
    logic need_minus;
    logic idx_zero;
    logic out_free;
  } sts_t;

  function automatic logic [5:0] decode_digit(input logic [7:0] c);
    logic [5:0] d;
    d = NOT_A_DIGIT;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 6'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = 6'(c - UPPER_OFFSET);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = 6'(c - LOWER_OFFSET);
    end
    return d;
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d <= LAST_DECIMAL) begin
      c = {2'b00, d} + CHAR_ZERO;
    end else begin
      c = {2'b00, d} + UPPER_OFFSET;
    end
    return c;
  endfunction

  function automatic logic base_ok(input logic [5:0] b);
    return (b >= BASE_MIN) && (b <= BASE_MAX);
  endfunction

endpackage

// ----- hdl/rsc_datapath.sv -----
// Datapath of the converter: base registers, accumulator, restoring divider and digit store.
module rsc_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [5:0]    cfg_data_i,
  input  logic [7:0]    in_char_i,
  input  logic          in_end_i,
  input  rsc_pkg::cmd_t cmd_i,
  output rsc_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_char_o,
  output logic          out_err_o,
  output logic          out_last_o
);
  import rsc_pkg::*;

  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int PROD_W  = VALUE_BITS + 6;
  localparam int SUM_W   = VALUE_BITS + 7;
  localparam int DIV_CYC = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W   = DIV_CYC * DIV_BITS;
  localparam int DCNT_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  logic [5:0]            src_radix_q, src_radix_d;
  logic [5:0]            tgt_base_q, tgt_base_d;
  logic [7:0]            char_q;
  logic                  end_q;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  first_q, first_d;
  logic                  seen_q, seen_d;
  logic                  err_q, err_d;
  logic                  upd_q, upd_d;
  logic [PROD_W-1:0]     prod_q;
  logic [5:0]            dig_q;
  logic [DIV_W-1:0]      work_q, work_d, work_next;
  logic [5:0]            rem_q, rem_d, rem_next;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [5:0]            dig_mem [VALUE_BITS];
  logic [5:0]            rd_q;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_err_q, out_err_d;
  logic                  out_last_q, out_last_d;

  logic [5:0]            cur_digit;
  logic                  is_sign;
  logic                  digit_ok;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      limit;
  logic                  digit_done;
  logic                  mem_we;

  assign cur_digit  = decode_digit(char_q);
  assign is_sign    = first_q && (char_q == CHAR_PLUS || char_q == CHAR_MINUS);
  assign digit_ok   = base_ok(src_radix_q) && (cur_digit < src_radix_q);
  assign sum        = SUM_W'(prod_q) + SUM_W'(dig_q);
  assign limit      = {{7{1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}} - SUM_W'(!neg_q);
  assign digit_done = (dcnt_q == DCNT_W'(DIV_CYC - 1));
  assign mem_we     = cmd_i.div_step && digit_done;

  // Eight restoring division steps per cycle on the narrow remainder.
  always_comb begin
    logic [DIV_W-1:0] w;
    logic [5:0]       r;
    logic [6:0]       r7;
    w = work_q;
    r = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      r7 = {r, w[DIV_W-1]};
      if (r7 >= {1'b0, tgt_base_q}) begin
        r7 = r7 - {1'b0, tgt_base_q};
        w  = {w[DIV_W-2:0], 1'b1};
      end else begin
        w  = {w[DIV_W-2:0], 1'b0};
      end
      r = r7[5:0];
    end
    work_next = w;
    rem_next  = r;
  end

  always_comb begin
    src_radix_d = src_radix_q;
    tgt_base_d  = tgt_base_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    first_d     = first_q;
    seen_d      = seen_q;
    err_d       = err_q;
    upd_d       = upd_q;
    work_d      = work_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_BASE: src_radix_d = cfg_data_i;
        CFG_TARGET_BASE: tgt_base_d = cfg_data_i;
      endcase
    end

    if (cmd_i.decode) begin
      first_d = 1'b0;
      upd_d   = 1'b0;
      if (is_sign) begin
        neg_d = (char_q == CHAR_MINUS);
      end else if (!digit_ok) begin
        err_d = 1'b1;
      end else begin
        seen_d = 1'b1;
        upd_d  = !err_q;
      end
    end

    if (cmd_i.update && upd_q) begin
      if (sum > limit) begin
        err_d = 1'b1;
      end else begin
        acc_d = sum[VALUE_BITS-1:0];
      end
    end

    if (cmd_i.div_load) begin
      work_d = DIV_W'(acc_q);
      rem_d  = '0;
      dcnt_d = '0;
      idx_d  = '0;
    end

    if (cmd_i.div_step) begin
      work_d = work_next;
      rem_d  = rem_next;
      if (digit_done) begin
        dcnt_d = '0;
        rem_d  = '0;
        if (work_next != '0) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end else begin
        dcnt_d = dcnt_q + DCNT_W'(1);
      end
    end

    if (cmd_i.emit_err) begin
      out_valid_d = 1'b1;
      out_char_d  = ERROR_CHAR;
      out_err_d   = 1'b1;
      out_last_d  = 1'b1;
    end else if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CHAR_MINUS;
      out_err_d   = 1'b0;
      out_last_d  = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = digit_char(rd_q);
      out_err_d   = 1'b0;
      out_last_d  = (idx_q == '0);
      if (idx_q != '0) begin
        idx_d = idx_q - IDX_W'(1);
      end
    end

    if (cmd_i.clear_num) begin
      acc_d   = '0;
      neg_d   = 1'b0;
      first_d = 1'b1;
      seen_d  = 1'b0;
      err_d   = 1'b0;
      upd_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_radix_q <= BASE_RESET;
      tgt_base_q  <= BASE_RESET;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      first_q     <= 1'b1;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
      upd_q       <= 1'b0;
      dcnt_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      src_radix_q <= src_radix_d;
      tgt_base_q  <= tgt_base_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      first_q     <= first_d;
      seen_q      <= seen_d;
      err_q       <= err_d;
      upd_q       <= upd_d;
      dcnt_q      <= dcnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char) begin
      char_q <= in_char_i;
      end_q  <= in_end_i;
    end
    if (cmd_i.decode) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(src_radix_q);
      dig_q  <= cur_digit;
    end
    work_q     <= work_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[idx_q] <= rem_next;
    end
    rd_q <= dig_mem[idx_d];
  end

  assign sts_o.end_mark   = end_q;
  assign sts_o.err_result = err_q || !seen_q || !base_ok(tgt_base_q);
  assign sts_o.digit_done = digit_done;
  assign sts_o.quot_zero  = (work_next == '0);
  assign sts_o.need_minus = neg_q && (acc_q != '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- hdl/rsc_ctrl.sv -----
// Controller state machine of the converter: sequences parsing, division and emission.
module rsc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsc_pkg::sts_t sts_i,
  output rsc_pkg::cmd_t cmd_o
);
  import rsc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_SIGN   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_char = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.end_mark ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (sts_i.err_result) begin
          if (sts_i.out_free) begin
            cmd_o.emit_err  = 1'b1;
            cmd_o.clear_num = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.digit_done && sts_i.quot_zero) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts_i.need_minus) begin
          state_d = ST_EMIT;
        end else if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.idx_zero) begin
            cmd_o.clear_num = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/radix_string_converter.sv -----
// Every character passes through accept, digit decode with multiply, then add and range check.
// The closing character adds a check step, then a division per digit (eight quotient bits a cycle),
// a sign step that carries the minus word of a negative value, then one digit word per cycle
// while the sink is ready. An invalid number gives its error word from the check state once the
// output is free. Reset clears the controller, number state and output valid, and sets both
// bases to 10; the digit store is not cleared, as each entry is written before it is read.
module radix_string_converter #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_code
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tuser,   // error_flag
  output logic       m_axis_tlast
);
  import rsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- hdl/rsc_checker.sv -----
// Port-level checker of the converter, bound to the top level.
`include "assert_macros.svh"

module rsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);
  import rsc_pkg::*;

  `RSC_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "Output word changed while stalled")
  `RSC_ASSERT(a_err_word,
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == ERROR_CHAR,
    "Error word is not a lone zero")
  `RSC_ASSERT(a_minus_not_last,
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata == CHAR_MINUS |-> !m_axis_tlast,
    "Minus sign closes a run")
  `RSC_ASSERT(a_char_busy,
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
    "Input taken on consecutive cycles")
  `RSC_ASSERT_ALWAYS(a_reset_quiet,
    !rst_ni |=> !m_axis_tvalid,
    "Output valid straight after reset")

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (.*);
